/* rtl/hcsq_pkg.sv */
// shared constants, payload types and control types for the histogram sort queue
package hcsq_pkg;

  localparam int VALUE_BITS = 10;
  localparam int COUNT_BITS = 16;
  localparam int NUM_BINS   = 1 << VALUE_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // command codes of an input word
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_TAKE   = 1'b1;

  typedef enum logic [1:0] {
    STATUS_TOOK     = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_INSERTED = 2'd2,
    STATUS_DROPPED  = 2'd3
  } status_t;

  typedef struct packed {
    logic                  command;
    logic [VALUE_BITS-1:0] value;
  } item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] sorted_value;
    logic                  last;
    status_t               status;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_INS_WR,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic ins_wr;
    logic scan_start;
    logic scan_next;
    logic take_wr;
    logic set_drop;
    logic set_empty;
    logic emit;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clear_last;
    logic is_take;
    logic full;
    logic count_zero;
    logic bounds_zero;
    logic bin_nonzero;
    logic at_high;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/hcsq_ram.sv */
// generic single write port, single read port ram with registered read
module hcsq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/hcsq_ctrl.sv */
// controller state machine for the histogram sort queue
module hcsq_ctrl import hcsq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_valid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.is_take) begin
          state_next = sts.count_zero ? ST_EMIT : ST_SCAN;
        end else begin
          state_next = sts.full ? ST_EMIT : ST_INS_WR;
        end
      end
      ST_INS_WR: begin
        state_next = ST_EMIT;
      end
      ST_SCAN: begin
        if (sts.bin_nonzero || sts.at_high) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        cmd.load   = item_valid;
      end
      ST_DECIDE: begin
        if (sts.is_take) begin
          cmd.set_empty  = sts.count_zero;
          cmd.scan_start = !sts.count_zero;
        end else begin
          cmd.set_drop = sts.full;
        end
      end
      ST_INS_WR: begin
        cmd.ins_wr = 1'b1;
      end
      ST_SCAN: begin
        // hit on the bin just read, else stop at the high bound, else keep going
        if (sts.bin_nonzero) begin
          cmd.take_wr = 1'b1;
        end else if (sts.at_high) begin
          cmd.set_empty = 1'b1;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* rtl/hcsq_dp.sv */
// datapath: bin store, bounds, element count, scan pointers and result register
module hcsq_dp import hcsq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  item_t      item,
  input  ctrl_cmd_t  cmd,
  output dp_status_t sts,
  output logic       result_valid,
  input  logic       result_ready,
  output result_t    result
);

  item_t                 item_q;
  logic [VALUE_BITS-1:0] low_bound;
  logic [VALUE_BITS-1:0] high_bound;
  logic [COUNT_BITS-1:0] element_count;
  logic [VALUE_BITS-1:0] clr_addr;
  logic [VALUE_BITS-1:0] scan_ptr;
  logic [VALUE_BITS-1:0] chk_ptr;
  result_t               res_q;
  logic                  last_one;

  logic                  wr_en;
  logic [VALUE_BITS-1:0] wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic [VALUE_BITS-1:0] rd_addr;
  logic [COUNT_BITS-1:0] rd_data;

  hcsq_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign last_one = (element_count == COUNT_BITS'(1));

  always_comb begin
    wr_en = cmd.clear | cmd.ins_wr | cmd.take_wr;
    if (cmd.clear) begin
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (cmd.ins_wr) begin
      wr_addr = item_q.value;
      wr_data = rd_data + COUNT_BITS'(1);
    end else begin
      wr_addr = chk_ptr;
      wr_data = rd_data - COUNT_BITS'(1);
    end
    // decide cycle reads the inserted bin or the low bound; scan reads ahead
    if (cmd.scan_next) begin
      rd_addr = scan_ptr;
    end else if (item_q.command == CMD_TAKE) begin
      rd_addr = low_bound;
    end else begin
      rd_addr = item_q.value;
    end
  end

  always_comb begin
    sts.clear_last  = &clr_addr;
    sts.is_take     = (item_q.command == CMD_TAKE);
    sts.full        = (element_count == COUNT_MAX);
    sts.count_zero  = (element_count == '0);
    sts.bounds_zero = (low_bound == '0) && (high_bound == '0);
    sts.bin_nonzero = (rd_data != '0);
    sts.at_high     = (chk_ptr == high_bound);
    sts.out_free    = !result_valid || result_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + VALUE_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
    if (cmd.scan_start) begin
      chk_ptr  <= low_bound;
      scan_ptr <= low_bound + VALUE_BITS'(1);
    end else if (cmd.scan_next) begin
      chk_ptr  <= scan_ptr;
      scan_ptr <= scan_ptr + VALUE_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_bound     <= '0;
      high_bound    <= '0;
      element_count <= '0;
    end else if (cmd.ins_wr) begin
      element_count <= element_count + COUNT_BITS'(1);
      if (element_count == '0) begin
        low_bound  <= item_q.value;
        high_bound <= item_q.value;
      end else begin
        if (item_q.value < low_bound)  low_bound  <= item_q.value;
        if (item_q.value > high_bound) high_bound <= item_q.value;
      end
    end else if (cmd.take_wr) begin
      element_count <= element_count - COUNT_BITS'(1);
      if (last_one) begin
        low_bound  <= '0;
        high_bound <= '0;
      end else begin
        low_bound <= chk_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_drop) begin
      res_q <= '{sorted_value: '0, last: 1'b0, status: STATUS_DROPPED};
    end else if (cmd.set_empty) begin
      res_q <= '{sorted_value: '0, last: 1'b0, status: STATUS_EMPTY};
    end else if (cmd.ins_wr) begin
      res_q <= '{sorted_value: '0, last: 1'b0, status: STATUS_INSERTED};
    end else if (cmd.take_wr) begin
      res_q <= '{sorted_value: chk_ptr, last: last_one, status: STATUS_TOOK};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result <= res_q;
    end
  end

endmodule

/* rtl/histogram_counting_sort_queue.sv */
// top level of the histogram sort queue: controller, datapath and checks
//
//   channel  dir  handshake                   word
//   item     in   item_valid / item_ready     item_t   {command, value}
//   result   out  result_valid / result_ready result_t {sorted_value, last, status}
//
// after reset a clearing pass zeroes all 1024 bins, one per cycle; item_ready stays low
// insert: accept, decide (bin read), bin write (skipped when full), emit
// take: accept, decide (read low bound), scan bin by bin from the low bound up to
//   the first nonzero bin or the high bound, emit; an empty store skips the scan
// one word in flight; the result register holds a word while the next one is accepted
// a stalled result only holds the controller in its emit state
module histogram_counting_sort_queue import hcsq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // state machine: clear pass, dispatch, insert, scan, emit
  hcsq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // bin store and bookkeeping registers
  hcsq_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef ASSERT_OFF
  // a take only lowers a bin that holds something, and only with a nonempty store
  a_take_hits_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.take_wr |-> (sts.bin_nonzero && !sts.count_zero))
    else $error("take write on empty bin or empty store");

  // an empty store always has both bounds back at zero
  a_empty_bounds_zero: assert property (@(posedge clk) disable iff (rst)
    sts.count_zero |-> sts.bounds_zero)
    else $error("bounds not cleared with empty store");

  // only one word in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("second word accepted while one is in flight");
`endif

endmodule

/* dv/sort_order_checker.sv */
// checker for the histogram sort queue: tracks held values and compares every result word
module sort_order_checker import hcsq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_ready,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_ready,
  input  result_t result,
  output int      mismatch_count,
  output int      words_in_flight
);

  // own histogram of the held values
  logic [COUNT_BITS-1:0] bin_tally [NUM_BINS];
  logic [VALUE_BITS-1:0] floor_value;
  logic [VALUE_BITS-1:0] ceiling_value;
  logic [COUNT_BITS-1:0] held_total;

  result_t awaited_results [$];
  result_t oldest_awaited;

  initial begin
    mismatch_count  = 0;
    words_in_flight = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
  endtask

  task automatic clear_histogram();
    for (int k = 0; k < NUM_BINS; k++) bin_tally[k] = '0;
    floor_value   = '0;
    ceiling_value = '0;
    held_total    = '0;
  endtask

  // applies one word to the histogram and returns the word it must produce
  function automatic result_t sort_step(input item_t w);
    result_t r;
    int      scan;
    bit      hit;
    r.sorted_value = '0;
    r.last         = 1'b0;
    r.status       = STATUS_EMPTY;
    if (w.command == CMD_INSERT) begin
      if (held_total == COUNT_MAX) begin
        r.status = STATUS_DROPPED;
      end else begin
        if (held_total == '0) begin
          floor_value   = w.value;
          ceiling_value = w.value;
        end else begin
          if (w.value < floor_value) floor_value = w.value;
          if (w.value > ceiling_value) ceiling_value = w.value;
        end
        bin_tally[w.value] = bin_tally[w.value] + 1'b1;
        held_total         = held_total + 1'b1;
        r.status           = STATUS_INSERTED;
      end
    end else if (held_total != '0) begin
      hit  = 1'b0;
      scan = int'(floor_value);
      while (!hit && scan <= int'(ceiling_value)) begin
        if (bin_tally[scan] != '0) hit = 1'b1;
        else scan++;
      end
      // no nonzero bin in the bounds stays an empty answer
      if (hit) begin
        bin_tally[scan] = bin_tally[scan] - 1'b1;
        held_total      = held_total - 1'b1;
        floor_value     = scan[VALUE_BITS-1:0];
        r.sorted_value  = scan[VALUE_BITS-1:0];
        r.status        = STATUS_TOOK;
        if (held_total == '0) begin
          floor_value   = '0;
          ceiling_value = '0;
          r.last        = 1'b1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_histogram();
      awaited_results.delete();
      words_in_flight <= 0;
    end else begin
      // a result leaving at this edge belongs to an earlier word
      if (result_valid && result_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result word", int'(result), 0);
        end else begin
          oldest_awaited = awaited_results.pop_front();
          if (result.sorted_value !== oldest_awaited.sorted_value)
            report_mismatch("sorted_value", int'(result.sorted_value),
                            int'(oldest_awaited.sorted_value));
          if (result.last !== oldest_awaited.last)
            report_mismatch("last", int'(result.last), int'(oldest_awaited.last));
          if (result.status !== oldest_awaited.status)
            report_mismatch("status", int'(result.status), int'(oldest_awaited.status));
        end
      end
      if (item_valid && item_ready)
        awaited_results.insert(awaited_results.size(), sort_step(item));
      words_in_flight <= awaited_results.size();
    end
  end

endmodule

/* dv/histogram_counting_sort_queue_tb.sv */
// testbench top for the histogram sort queue: stimulus, watchdog and verdict
module histogram_counting_sort_queue_tb import hcsq_pkg::*; ();

  // a take may scan every bin and the clearing pass walks all of them,
  // so the quiet limit sits a few times above a full sweep
  localparam int QUIET_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = 50;
  localparam int RANDOM_WORDS  = 750;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  int      mismatch_count;
  int      words_in_flight;

  // gaps on both channels are only drawn while this is set
  bit      gaps_on;
  int      words_sent;
  // values the block should be holding, kept only to shape the stimulus
  int      held_now;
  int      quiet_cycles;

  histogram_counting_sort_queue dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  sort_order_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .item            (item),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result          (result),
    .mismatch_count  (mismatch_count),
    .words_in_flight (words_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: counts edges at which neither channel moves a word
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // result side: a fresh stall is drawn before each word is taken
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      stall = gaps_on ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      @(negedge clk);
    end
  end

  // drive one word; called and left at a falling edge
  task automatic send_word(input logic cmd, input logic [VALUE_BITS-1:0] v);
    item_t w;
    int    gap;
    w.command = cmd;
    w.value   = v;
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    // valid stays up with the word unchanged until the edge that takes it
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
    words_sent++;
    if (cmd == CMD_INSERT) begin
      if (held_now < int'(COUNT_MAX)) held_now++;
    end else if (held_now > 0) begin
      held_now--;
    end
  endtask

  task automatic insert_word(input logic [VALUE_BITS-1:0] v);
    send_word(CMD_INSERT, v);
  endtask

  // the value field is don't-care on a take, so it carries noise
  task automatic take_word();
    send_word(CMD_TAKE, VALUE_BITS'($urandom_range(0, NUM_BINS - 1)));
  endtask

  // hold the sender back until every result has come out
  task automatic wait_for_quiet();
    item_valid <= 1'b0;
    while (words_in_flight != 0) @(negedge clk);
  endtask

  // mostly clustered near the burst base so scans stay short
  function automatic logic [VALUE_BITS-1:0] pick_value(input int base);
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return VALUE_BITS'(base + $urandom_range(0, 15));
    if (r < 9) return VALUE_BITS'($urandom_range(0, NUM_BINS - 1));
    return $urandom_range(0, 1) ? '0 : '1;
  endfunction

  // a burst of inserts mixed with takes, usually drained to the last word
  task automatic random_burst();
    int base;
    int inserts_left;
    bit drain;
    base         = $urandom_range(0, NUM_BINS - 16);
    inserts_left = $urandom_range(1, 12);
    drain        = ($urandom_range(0, 3) != 0);
    gaps_on      = ($urandom_range(0, 4) != 0);
    // noise: a take on a store that may well be empty
    if ($urandom_range(0, 5) == 0) take_word();
    while (inserts_left > 0) begin
      if (held_now == 0 || $urandom_range(0, 2) != 0) begin
        insert_word(pick_value(base));
        inserts_left--;
      end else begin
        take_word();
      end
    end
    if (drain) begin
      while (held_now > 0) take_word();
      if ($urandom_range(0, 1) == 1) take_word();
    end
    if ($urandom_range(0, 7) == 0) wait_for_quiet();
  endtask

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_ready = 1'b0;
    gaps_on      = 1'b1;
    words_sent   = 0;
    held_now     = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty take, both ends of the range, duplicates, drain to last
    take_word();
    insert_word('0);
    insert_word('1);
    insert_word('1);
    insert_word(VALUE_BITS'(512));
    insert_word('0);
    repeat (5) take_word();
    take_word();
    // first insert after draining resets both bounds
    insert_word(VALUE_BITS'(5));
    insert_word(VALUE_BITS'(3));
    take_word();
    insert_word(VALUE_BITS'(4));
    take_word();
    take_word();
    insert_word('1);
    take_word();
    wait_for_quiet();

    // random bursts, then whatever is left is drained
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) random_burst();
    gaps_on = 1'b1;
    while (held_now > 0) take_word();
    take_word();

    item_valid <= 1'b0;
    while (words_in_flight != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && words_in_flight == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
